/* rtl/tga_rle_pixel_decoder_core_macros.svh */
// Assertion macros shared by the TGA RLE pixel decoder RTL.
// Depends on nothing; included by the modules that carry assertions.
// Simulation builds get the checks; synthesis builds get empty bodies.
`ifndef TGA_RLE_PIXEL_DECODER_CORE_MACROS_SVH
`define TGA_RLE_PIXEL_DECODER_CORE_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked at every rising edge outside reset.
`define TGARLE_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tgarle same-cycle check failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define TGARLE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tgarle next-cycle check failed");

`else

`define TGARLE_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define TGARLE_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

/* rtl/tgarle_pkg.sv */
// Shared types and constants for the TGA RLE pixel decoder.
// No dependencies; imported by every module of the block.
`default_nettype none

package tgarle_pkg;

    // Configuration register indexes.
    localparam logic [1:0] REG_IMAGE_MODE      = 2'd0;
    localparam logic [1:0] REG_BYTES_PER_PIXEL = 2'd1;
    localparam logic [1:0] REG_ALPHA_ENABLE    = 2'd2;
    localparam logic [1:0] REG_PIXEL_COUNT     = 2'd3;

    // Image mode bits.
    localparam int MODE_RLE_BIT  = 0;
    localparam int MODE_GRAY_BIT = 1;

    // RLE packet header fields.
    localparam int         HDR_RUN_BIT   = 7;
    localparam logic [6:0] HDR_COUNT_MAX = 7'h7f;

    localparam logic [7:0] OPAQUE_ALPHA = 8'd255;

    // Effective pixel size after clamping bytes_per_pixel to 2..4.
    typedef enum logic [1:0] {
        PIX_2B,
        PIX_3B,
        PIX_4B
    } t_pix_size;

    // Controls handed to the pixel converter.
    typedef struct packed {
        logic      gray;
        logic      alpha_enable;
        t_pix_size size;
    } t_conv_ctrl;

    // One result beat.
    typedef struct packed {
        logic [31:0] pixel_word;
        logic [7:0]  repeat_count;
        logic        last_pixel;
        logic        overrun;
    } t_result;

endpackage

`default_nettype wire

/* rtl/tga_rle_pixel_decoder_core.sv */
// Top level of the TGA RLE pixel decoder: packet parsing, pixel assembly and run bookkeeping.
// Depends on tgarle_pkg, tgarle_convert, tgarle_out_buf and the assertion macro header.
`default_nettype none

// The decoder takes the pixel-data bytes of a TGA image (everything after the file
// header) as one beat per byte and returns one beat per distinct pixel: the pixel
// converted to RGBA order, the number of times it occurs in a row (1 to 128), a flag
// on the beat that completes the image and a flag when a packet ran past the image
// end, in which case the repeat count is clipped to the pixels that remain. In the
// RLE modes the packet header bytes and the non-final bytes of a pixel produce no
// beat. One byte is accepted every clock cycle: the packet, pixel and count state is
// updated at each accepted byte, and the finished pixel goes to a two-entry output
// buffer, so input ready only drops when two results are waiting at the output. Once
// the image is complete, further bytes are accepted and dropped until reset or a pixel
// count write. Configuration registers (image mode, bytes per pixel, alpha enable,
// pixel count) are written through a plain write port and must only change while no
// result is outstanding; a partial pixel and the packet state survive a change.
module tga_rle_pixel_decoder_core (
    input  var logic        i_clk,
    input  var logic        i_rst_n,
    // Configuration write port.
    input  var logic        i_cfg_we,
    input  var logic [1:0]  i_cfg_index,
    input  var logic [31:0] i_cfg_wdata,
    // Byte input channel.
    input  var logic        i_valid,
    output var logic        o_ready,
    input  var logic [7:0]  i_data_byte,
    // Pixel result channel.
    output var logic        o_valid,
    input  var logic        i_ready,
    output var logic [31:0] o_pixel_word,
    output var logic [7:0]  o_repeat_count,
    output var logic        o_last_pixel,
    output var logic        o_overrun
);
    import tgarle_pkg::*;

    `include "tga_rle_pixel_decoder_core_macros.svh"

    // Configuration registers.
    logic [1:0]  r_image_mode;
    logic [2:0]  r_bytes_per_pixel;
    logic        r_alpha_enable;

    // Decode state. The image position is kept as the signed difference between
    // the pixel count and the pixels already emitted, so that a step needs only
    // one subtract; the emitted count itself is kept to rebuild it on a write.
    logic        r_expect_header;
    logic        r_run_packet;
    logic [6:0]  r_packet_left;
    logic [1:0]  r_byte_slot;
    logic [23:0] r_pixel_bytes;
    logic [31:0] r_pixels_done;
    logic [32:0] r_remaining;

    logic        n_expect_header;
    logic        n_run_packet;
    logic [6:0]  n_packet_left;
    logic [1:0]  n_byte_slot;
    logic [23:0] n_pixel_bytes;

    logic        accept;
    logic        buf_full;
    logic        is_rle;
    logic        finished;
    logic [2:0]  eff_bytes;
    t_conv_ctrl  conv_ctrl;
    logic [31:0] conv_word;
    logic        take_header;
    logic        partial_byte;
    logic        pixel_done;

    logic [7:0]  run_total;
    logic        rem_big;
    logic        rem_one;
    logic        clip;
    logic [7:0]  push_rep;
    logic        push_ov;
    logic        push_last;
    logic        push;
    t_result     push_data;
    t_result     out_data;

    assign accept = i_valid && o_ready;
    assign o_ready = !buf_full;

    assign is_rle   = r_image_mode[MODE_RLE_BIT];
    assign finished = r_remaining[32] || (r_remaining == 33'd0);

    // Clamp bytes per pixel to the supported 2..4 range.
    always_comb begin
        conv_ctrl.gray         = r_image_mode[MODE_GRAY_BIT];
        conv_ctrl.alpha_enable = r_alpha_enable;
        if (r_bytes_per_pixel < 3'd2) begin
            eff_bytes      = 3'd2;
            conv_ctrl.size = PIX_2B;
        end else if (r_bytes_per_pixel > 3'd4) begin
            eff_bytes      = 3'd4;
            conv_ctrl.size = PIX_4B;
        end else begin
            eff_bytes      = r_bytes_per_pixel;
            conv_ctrl.size = (r_bytes_per_pixel == 3'd2) ? PIX_2B :
                             (r_bytes_per_pixel == 3'd3) ? PIX_3B : PIX_4B;
        end
    end

    tgarle_convert u_convert (
        .i_ctrl       (conv_ctrl),
        .i_held_bytes (r_pixel_bytes),
        .i_last_byte  (i_data_byte),
        .o_pixel_word (conv_word)
    );

    // Byte classification for an accepted beat.
    assign take_header  = !finished && is_rle && r_expect_header;
    assign partial_byte = !finished && !take_header
                          && (({1'b0, r_byte_slot} + 3'd1) < eff_bytes);
    assign pixel_done   = !finished && !take_header && !partial_byte;

    // Repeat count and clipping. A run is at most 128 pixels, so it only needs
    // clipping when fewer than 128 pixels remain.
    assign run_total = {1'b0, r_packet_left} + 8'd1;
    assign rem_big   = |r_remaining[32:7];
    assign rem_one   = (r_remaining == 33'd1);
    assign clip      = is_rle && r_run_packet && !rem_big
                       && (run_total > {1'b0, r_remaining[6:0]});

    always_comb begin
        push_ov = 1'b0;
        if (!is_rle) begin
            push_rep = 8'd1;
        end else if (r_run_packet) begin
            push_rep = clip ? {1'b0, r_remaining[6:0]} : run_total;
            push_ov  = clip;
        end else begin
            push_rep = 8'd1;
            push_ov  = rem_one && (r_packet_left != 7'd0);
        end
    end

    assign push_last = (r_remaining == {25'd0, push_rep});
    assign push      = accept && pixel_done;

    assign push_data.pixel_word   = conv_word;
    assign push_data.repeat_count = push_rep;
    assign push_data.last_pixel   = push_last;
    assign push_data.overrun      = push_ov;

    // Next packet and pixel-assembly state.
    always_comb begin
        n_expect_header = r_expect_header;
        n_run_packet    = r_run_packet;
        n_packet_left   = r_packet_left;
        n_byte_slot     = r_byte_slot;
        n_pixel_bytes   = r_pixel_bytes;
        if (take_header) begin
            n_run_packet    = i_data_byte[HDR_RUN_BIT];
            n_packet_left   = i_data_byte[6:0] & HDR_COUNT_MAX;
            n_expect_header = 1'b0;
        end else if (partial_byte) begin
            case (r_byte_slot)
                2'd0:    n_pixel_bytes[7:0]   = r_pixel_bytes[7:0] | i_data_byte;
                2'd1:    n_pixel_bytes[15:8]  = r_pixel_bytes[15:8] | i_data_byte;
                2'd2:    n_pixel_bytes[23:16] = r_pixel_bytes[23:16] | i_data_byte;
                default: n_pixel_bytes        = r_pixel_bytes;
            endcase
            n_byte_slot = r_byte_slot + 2'd1;
        end else if (pixel_done) begin
            n_byte_slot   = 2'd0;
            n_pixel_bytes = 24'd0;
            if (is_rle) begin
                if (r_run_packet || (r_packet_left == 7'd0)) begin
                    n_packet_left   = 7'd0;
                    n_expect_header = 1'b1;
                end else begin
                    n_packet_left = r_packet_left - 7'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_mode      <= 2'd0;
            r_bytes_per_pixel <= 3'd4;
            r_alpha_enable    <= 1'b0;
            r_expect_header   <= 1'b1;
            r_run_packet      <= 1'b0;
            r_packet_left     <= 7'd0;
            r_byte_slot       <= 2'd0;
            r_pixel_bytes     <= 24'd0;
            r_pixels_done     <= 32'd0;
            r_remaining       <= 33'd1;
        end else begin
            if (accept) begin
                r_expect_header <= n_expect_header;
                r_run_packet    <= n_run_packet;
                r_packet_left   <= n_packet_left;
                r_byte_slot     <= n_byte_slot;
                r_pixel_bytes   <= n_pixel_bytes;
                if (pixel_done) begin
                    r_pixels_done <= r_pixels_done + {24'd0, push_rep};
                    r_remaining   <= r_remaining - {25'd0, push_rep};
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_IMAGE_MODE:      r_image_mode      <= i_cfg_wdata[1:0];
                    REG_BYTES_PER_PIXEL: r_bytes_per_pixel <= i_cfg_wdata[2:0];
                    REG_ALPHA_ENABLE:    r_alpha_enable    <= i_cfg_wdata[0];
                    REG_PIXEL_COUNT: begin
                        r_remaining <= {1'b0, i_cfg_wdata} - {1'b0, r_pixels_done};
                    end
                    default: r_image_mode <= r_image_mode;
                endcase
            end
        end
    end

    tgarle_out_buf u_out_buf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data (push_data),
        .o_full      (buf_full),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_data      (out_data)
    );

    assign o_pixel_word   = out_data.pixel_word;
    assign o_repeat_count = out_data.repeat_count;
    assign o_last_pixel   = out_data.last_pixel;
    assign o_overrun      = out_data.overrun;

    // A result always repeats at least once and never more than one full run.
    `TGARLE_ASSERT_NOW(a_rep_in_range, i_clk, i_rst_n, push,
        push_rep != 8'd0 && push_rep <= 8'd128)
    // A finished image leaves the pixel position untouched.
    `TGARLE_ASSERT_NEXT(a_done_is_frozen, i_clk, i_rst_n,
        accept && finished && !i_cfg_we, $stable(r_pixels_done))
    // Overrun is only reported on the beat that completes the image.
    `TGARLE_ASSERT_NOW(a_overrun_at_end, i_clk, i_rst_n, push && push_ov, push_last)
    // The raw modes never carry a repeat count above one.
    `TGARLE_ASSERT_NOW(a_raw_single, i_clk, i_rst_n, push && !is_rle,
        push_rep == 8'd1 && !push_ov)

endmodule

`default_nettype wire

/* rtl/tgarle_convert.sv */
// Pixel format converter of the TGA RLE pixel decoder.
// Depends on tgarle_pkg; purely combinational.
`default_nettype none

module tgarle_convert (
    input  var tgarle_pkg::t_conv_ctrl i_ctrl,
    input  var logic [23:0]            i_held_bytes,
    input  var logic [7:0]             i_last_byte,
    output var logic [31:0]            o_pixel_word
);
    import tgarle_pkg::*;

    logic [7:0]  b0, b1, b2, b3;
    logic [15:0] v16;
    logic        a16;
    logic [7:0]  alpha_sel;

    // The byte that completes the pixel lands in slot size-1; later slots read zero.
    always_comb begin
        b0 = i_held_bytes[7:0];
        b1 = i_held_bytes[15:8];
        b2 = i_held_bytes[23:16];
        b3 = 8'd0;
        case (i_ctrl.size)
            PIX_2B:  b1 = i_last_byte;
            PIX_3B:  b2 = i_last_byte;
            PIX_4B:  b3 = i_last_byte;
            default: b3 = i_last_byte;
        endcase
    end

    assign v16 = {b1, b0};
    assign a16 = i_ctrl.alpha_enable ? v16[15] : 1'b1;

    always_comb begin
        if (i_ctrl.gray) begin
            alpha_sel = i_ctrl.alpha_enable ? b1 : OPAQUE_ALPHA;
            o_pixel_word = {16'd0, alpha_sel, b0};
        end else begin
            alpha_sel = i_ctrl.alpha_enable ? b3 : OPAQUE_ALPHA;
            case (i_ctrl.size)
                PIX_2B:  o_pixel_word = {16'd0, v16[14:0], a16};
                PIX_3B:  o_pixel_word = {8'd0, b0, b1, b2};
                PIX_4B:  o_pixel_word = {alpha_sel, b0, b1, b2};
                default: o_pixel_word = {alpha_sel, b0, b1, b2};
            endcase
        end
    end

endmodule

`default_nettype wire

/* rtl/tgarle_out_buf.sv */
// Two-entry result buffer (output register plus skid entry).
// Depends on tgarle_pkg and the assertion macro header.
`default_nettype none

module tgarle_out_buf (
    input  var logic                i_clk,
    input  var logic                i_rst_n,
    input  var logic                i_push,
    input  var tgarle_pkg::t_result i_push_data,
    output var logic                o_full,
    output var logic                o_valid,
    input  var logic                i_ready,
    output var tgarle_pkg::t_result o_data
);
    import tgarle_pkg::*;

    `include "tga_rle_pixel_decoder_core_macros.svh"

    logic    r_main_v, r_skid_v;
    t_result r_main, r_skid;
    logic    pop;

    assign pop     = r_main_v && i_ready;
    assign o_valid = r_main_v;
    assign o_data  = r_main;
    assign o_full  = r_skid_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_v <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (pop || !r_main_v) begin
            // The main entry is free: refill from skid first to keep order.
            if (r_skid_v) begin
                r_main   <= r_skid;
                r_main_v <= 1'b1;
                r_skid_v <= i_push;
                if (i_push) begin
                    r_skid <= i_push_data;
                end
            end else begin
                r_main_v <= i_push;
                if (i_push) begin
                    r_main <= i_push_data;
                end
            end
        end else if (i_push) begin
            r_skid   <= i_push_data;
            r_skid_v <= 1'b1;
        end
    end

    `TGARLE_ASSERT_NOW(a_skid_needs_main, i_clk, i_rst_n, r_skid_v, r_main_v)
    `TGARLE_ASSERT_NEXT(a_push_lands, i_clk, i_rst_n, i_push && !r_skid_v, r_main_v)
    `TGARLE_ASSERT_NEXT(a_held_beat_kept, i_clk, i_rst_n,
        r_main_v && !i_ready, r_main_v && o_data == $past(r_main))

endmodule

`default_nettype wire
